// ----- src/cpwf_pkg.sv -----
// Package for the cheapest price window finder.
// Widths, limits and the summary type shared by the tracker core and the top level.
// No dependencies.
package cpwf_pkg;

    localparam int MAX_POINTS = 64;
    localparam int POS_W      = $clog2(MAX_POINTS);
    localparam int PRICE_W    = 32;
    localparam int SUM_W      = 35;
    localparam int IDX_W      = 6;
    localparam int RECENT_D   = 4;
    localparam int OUT_DATA_W = 88;

    typedef struct packed {
        logic signed [PRICE_W-1:0] min_price;
        logic signed [PRICE_W-1:0] max_price;
        logic                      best_one_found;
        logic [IDX_W-1:0]          best_one_index;
        logic                      best_three_found;
        logic [IDX_W-1:0]          best_three_index;
        logic                      best_six_found;
        logic [IDX_W-1:0]          best_six_index;
    } summary_t;

endpackage

// ----- src/cpwf_core.sv -----
// Price tracker core: series state, window sums and best-window search.
// Updates its state on step and presents, combinationally, the summary that includes the pending request.
// Depends on cpwf_pkg.
module cpwf_core
    import cpwf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic                      start,
    input  logic                      missing,
    input  logic signed [PRICE_W-1:0] price,
    output summary_t                  summary
);

    logic signed [PRICE_W-1:0] recent_reg [RECENT_D];
    logic signed [PRICE_W-1:0] recent_next [RECENT_D];
    logic signed [SUM_W-1:0]   sum2_reg, sum2_next;
    logic signed [SUM_W-1:0]   sum5_reg, sum5_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic                      stopped_reg, stopped_next;
    logic                      any_valid_reg, any_valid_next;
    logic signed [PRICE_W-1:0] low_reg, low_next;
    logic signed [PRICE_W-1:0] high_reg, high_next;
    logic signed [PRICE_W-1:0] best1_reg, best1_next;
    logic signed [SUM_W-1:0]   best3_reg, best3_next;
    logic signed [SUM_W-1:0]   best6_reg, best6_next;
    logic                      found1_reg, found1_next;
    logic                      found3_reg, found3_next;
    logic                      found6_reg, found6_next;
    logic [IDX_W-1:0]          idx1_reg, idx1_next;
    logic [IDX_W-1:0]          idx3_reg, idx3_next;
    logic [IDX_W-1:0]          idx6_reg, idx6_next;

    logic                      take;
    logic signed [SUM_W-1:0]   price_ext;
    logic signed [SUM_W-1:0]   sum3;
    logic signed [SUM_W-1:0]   sum6;
    logic signed [PRICE_W-1:0] rb [RECENT_D];
    logic [POS_W-1:0]          pos_base;

    always_comb
    begin
        // a start clears the series before this price is looked at
        for (int k = 0; k < RECENT_D; k++)
        begin
            rb[k] = start ? '0 : recent_reg[k];
        end
        pos_base       = start ? '0 : pos_reg;
        sum2_next      = start ? '0 : sum2_reg;
        sum5_next      = start ? '0 : sum5_reg;
        any_valid_next = start ? 1'b0 : any_valid_reg;
        low_next       = start ? '0 : low_reg;
        high_next      = start ? '0 : high_reg;
        best1_next     = start ? '0 : best1_reg;
        best3_next     = start ? '0 : best3_reg;
        best6_next     = start ? '0 : best6_reg;
        found1_next    = start ? 1'b0 : found1_reg;
        found3_next    = start ? 1'b0 : found3_reg;
        found6_next    = start ? 1'b0 : found6_reg;
        idx1_next      = start ? '0 : idx1_reg;
        idx3_next      = start ? '0 : idx3_reg;
        idx6_next      = start ? '0 : idx6_reg;
        recent_next    = rb;
        pos_next       = pos_base;

        stopped_next = (start ? 1'b0 : stopped_reg) | missing;
        take         = !(start ? 1'b0 : stopped_reg) && !missing;

        price_ext = SUM_W'(price);
        sum3      = price_ext + sum2_next;
        sum6      = price_ext + sum5_next;

        if (take)
        begin
            if (!any_valid_next || price < low_next)
            begin
                low_next = price;
            end
            if (!any_valid_next || price > high_next)
            begin
                high_next = price;
            end
            any_valid_next = 1'b1;

            if (!found1_next || price < best1_next)
            begin
                best1_next  = price;
                found1_next = 1'b1;
                idx1_next   = IDX_W'(pos_base);
            end
            if (pos_base >= POS_W'(2) && (!found3_next || sum3 < best3_next))
            begin
                best3_next  = sum3;
                found3_next = 1'b1;
                idx3_next   = IDX_W'(pos_base - POS_W'(2));
            end
            if (pos_base >= POS_W'(5) && (!found6_next || sum6 < best6_next))
            begin
                best6_next  = sum6;
                found6_next = 1'b1;
                idx6_next   = IDX_W'(pos_base - POS_W'(5));
            end

            // advance the delay line and the partial sums for the next price
            recent_next[0] = price;
            for (int k = 1; k < RECENT_D; k++)
            begin
                recent_next[k] = rb[k-1];
            end
            sum2_next = price_ext + SUM_W'(rb[0]);
            sum5_next = price_ext + SUM_W'(rb[0]) + SUM_W'(rb[1])
                      + SUM_W'(rb[2]) + SUM_W'(rb[3]);

            if (pos_base == POS_W'(MAX_POINTS - 1))
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                pos_next = pos_base + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < RECENT_D; k++)
            begin
                recent_reg[k] <= '0;
            end
            sum2_reg      <= '0;
            sum5_reg      <= '0;
            pos_reg       <= '0;
            stopped_reg   <= 1'b1;
            any_valid_reg <= 1'b0;
            low_reg       <= '0;
            high_reg      <= '0;
            best1_reg     <= '0;
            best3_reg     <= '0;
            best6_reg     <= '0;
            found1_reg    <= 1'b0;
            found3_reg    <= 1'b0;
            found6_reg    <= 1'b0;
            idx1_reg      <= '0;
            idx3_reg      <= '0;
            idx6_reg      <= '0;
        end
        else if (step)
        begin
            recent_reg    <= recent_next;
            sum2_reg      <= sum2_next;
            sum5_reg      <= sum5_next;
            pos_reg       <= pos_next;
            stopped_reg   <= stopped_next;
            any_valid_reg <= any_valid_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            best1_reg     <= best1_next;
            best3_reg     <= best3_next;
            best6_reg     <= best6_next;
            found1_reg    <= found1_next;
            found3_reg    <= found3_next;
            found6_reg    <= found6_next;
            idx1_reg      <= idx1_next;
            idx3_reg      <= idx3_next;
            idx6_reg      <= idx6_next;
        end
    end

    // min and max stay zero until a valid price arrives
    always_comb
    begin
        summary.min_price        = low_next;
        summary.max_price        = high_next;
        summary.best_one_found   = found1_next;
        summary.best_one_index   = idx1_next;
        summary.best_three_found = found3_next;
        summary.best_three_index = idx3_next;
        summary.best_six_found   = found6_next;
        summary.best_six_index   = idx6_next;
    end

endmodule

// ----- src/cheapest_price_window_finder_unit.sv -----
// An accepted request is held in the input register, then its summary in the output register.
// Throughput: one request per cycle while the master side does not stall; the core's
// combinational state update (two-input window adds plus compares against the stored best) sets that rate.
// A full output register that the master does not take stalls the input register; both hold under backpressure.
// Reset (rst_n low, asynchronous) empties both stages and stops the tracker until
// the first request with series_start set.
module cheapest_price_window_finder_unit
    import cpwf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PRICE_W-1:0]    s_axis_tdata,  // [31:0] price
    input  logic [1:0]            s_axis_tuser,  // [0] series_start, [1] price_missing
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] min_price, [63:32] max_price, [64] best_one_found, [70:65] best_one_index,
    // [71] best_three_found, [77:72] best_three_index, [78] best_six_found,
    // [84:79] best_six_index, [87:85] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic                      in_valid_reg;
    logic                      in_start_reg;
    logic                      in_missing_reg;
    logic signed [PRICE_W-1:0] in_price_reg;
    logic                      out_valid_reg, out_valid_next;
    summary_t                  out_sum_reg;
    summary_t                  summary;
    logic                      advance;
    logic                      in_load;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_start_reg   <= s_axis_tuser[0];
            in_missing_reg <= s_axis_tuser[1];
            in_price_reg   <= s_axis_tdata;
        end
        if (advance)
        begin
            out_sum_reg <= summary;
        end
    end

    cpwf_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .start   (in_start_reg),
        .missing (in_missing_reg),
        .price   (in_price_reg),
        .summary (summary)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            out_sum_reg.best_six_index,   out_sum_reg.best_six_found,
                            out_sum_reg.best_three_index, out_sum_reg.best_three_found,
                            out_sum_reg.best_one_index,   out_sum_reg.best_one_found,
                            out_sum_reg.max_price,        out_sum_reg.min_price};

endmodule

// ----- src/cpwf_checker.sv -----
// Port-level checks for the cheapest price window finder.
// Bound to cheapest_price_window_finder_unit; depends on cpwf_pkg.
module cpwf_checker
    import cpwf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // a held summary must not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("summary changed while stalled");

    // once any price is taken, min never exceeds max
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[64] |->
            $signed(m_axis_tdata[31:0]) <= $signed(m_axis_tdata[63:32]))
        else $error("min above max");

    // a longer window is only found after the shorter ones
    a_nest: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (!m_axis_tdata[78] || m_axis_tdata[71]) && (!m_axis_tdata[71] || m_axis_tdata[64]))
        else $error("window found flags out of order");

    // with nothing taken, every field reads zero
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[64] |-> m_axis_tdata == '0)
        else $error("empty summary not zero");

endmodule

bind cheapest_price_window_finder_unit cpwf_checker u_cpwf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
